// ===== design/ple_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the positional list engine.
// No dependencies; used by ple_ram users and the top level.
package ple_pkg;

  localparam int CAP     = 64;
  localparam int ADDR_W  = $clog2(CAP);
  localparam int CMD_W   = 4;
  localparam int POS_W   = 8;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 3;
  localparam int FOUND_W = 7;
  localparam int CNT_W   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 4'd0,
    CMD_INS_BACK  = 4'd1,
    CMD_INS_AT    = 4'd2,
    CMD_DEL_FRONT = 4'd3,
    CMD_DEL_BACK  = 4'd4,
    CMD_DEL_AT    = 4'd5,
    CMD_READ      = 4'd6,
    CMD_FIND      = 4'd7,
    CMD_CLEAR     = 4'd8
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

endpackage

// ===== design/ple_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/positional_list_engine.sv =====
`timescale 1ns / 1ps
// Ordered list of up to ple_pkg::CAP signed words in one RAM, one command at a time.
// Errors and clear go straight to the result; read waits on the registered RAM read;
// insert/delete shift the entries behind pos, and find scans entries until a hit or the end.
// Input is stalled until the result is loaded, so a new command waits for the last one to finish.
// Synchronous reset empties the list (count zero); RAM contents are not cleared.
// Depends on ple_pkg and ple_ram.
module positional_list_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ple_pkg::CMD_W-1:0]     command,
  input  logic [ple_pkg::POS_W-1:0]     position,
  input  logic signed [ple_pkg::DATA_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ple_pkg::STAT_W-1:0]    status,
  output logic signed [ple_pkg::DATA_W-1:0] read_value,
  output logic [ple_pkg::FOUND_W-1:0]   found_position,
  output logic [ple_pkg::CNT_W-1:0]     entry_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_FIND,
    S_RESP
  } state_t;

  state_t                        state;
  logic [ple_pkg::CNT_W-1:0]     count;
  logic [ple_pkg::CNT_W-1:0]     idx;
  logic [ple_pkg::CNT_W-1:0]     pos;
  logic [ple_pkg::DATA_W-1:0]    val;
  logic                          pend;
  logic [ple_pkg::ADDR_W-1:0]    pend_addr;
  ple_pkg::status_t              res_status;
  logic [ple_pkg::DATA_W-1:0]    res_read;
  logic [ple_pkg::FOUND_W-1:0]   res_found;

  logic                          wr_en;
  logic [ple_pkg::ADDR_W-1:0]    wr_addr;
  logic [ple_pkg::DATA_W-1:0]    wr_data;
  logic                          rd_en;
  logic [ple_pkg::ADDR_W-1:0]    rd_addr;
  logic [ple_pkg::DATA_W-1:0]    rd_data;

  logic                          accept;
  logic [ple_pkg::CNT_W-1:0]     count_m1;
  logic [ple_pkg::CNT_W-1:0]     idx_m1;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign count_m1 = count - ple_pkg::CNT_W'(1);
  assign idx_m1   = idx - ple_pkg::CNT_W'(1);

  ple_ram #(
    .WIDTH (ple_pkg::DATA_W),
    .DEPTH (ple_pkg::CAP)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // RAM port control. During a shift, a read issued in one cycle is written back the next,
  // always to a different address than the read in flight.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = idx[ple_pkg::ADDR_W-1:0];
    case (state)
      S_INS: begin
        rd_addr = idx_m1[ple_pkg::ADDR_W-1:0];
        if (idx > pos) begin
          rd_en = 1'b1;
        end
        if (pend) begin
          wr_en = 1'b1;
        end else if (idx == pos) begin
          wr_en   = 1'b1;
          wr_addr = pos[ple_pkg::ADDR_W-1:0];
          wr_data = val;
        end
      end
      S_DEL: begin
        rd_en = (idx < count);
        wr_en = pend;
      end
      S_RD_ISSUE: begin
        rd_en   = 1'b1;
        rd_addr = pos[ple_pkg::ADDR_W-1:0];
      end
      S_FIND: begin
        rd_en = (idx < count);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // S_RESP owns out_valid in its own cycle
      if (out_valid && !out_stall && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend       <= 1'b0;
            val        <= value;
            res_status <= ple_pkg::ST_OK;
            res_read   <= '0;
            res_found  <= '0;
            state      <= S_RESP;
            case (ple_pkg::cmd_t'(command))
              ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_BACK, ple_pkg::CMD_INS_AT: begin
                logic [ple_pkg::CNT_W-1:0] p;
                p = (command == ple_pkg::CMD_INS_FRONT) ? '0 :
                    (command == ple_pkg::CMD_INS_BACK)  ? count : position;
                if (p > count) begin
                  res_status <= ple_pkg::ST_BADPOS;
                end else if (count >= ple_pkg::CNT_W'(ple_pkg::CAP)) begin
                  res_status <= ple_pkg::ST_FULL;
                end else begin
                  pos   <= p;
                  idx   <= count;
                  state <= S_INS;
                end
              end
              ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_BACK, ple_pkg::CMD_DEL_AT: begin
                logic [ple_pkg::CNT_W-1:0] p;
                p = (command == ple_pkg::CMD_DEL_FRONT) ? '0 :
                    (command == ple_pkg::CMD_DEL_BACK)  ? count_m1 : position;
                if (count == '0) begin
                  res_status <= ple_pkg::ST_EMPTY;
                end else if (p >= count) begin
                  res_status <= ple_pkg::ST_BADPOS;
                end else begin
                  pos   <= p;
                  idx   <= p + ple_pkg::CNT_W'(1);
                  state <= S_DEL;
                end
              end
              ple_pkg::CMD_READ: begin
                if (position < count) begin
                  pos   <= position;
                  state <= S_RD_ISSUE;
                end else begin
                  res_status <= ple_pkg::ST_BADPOS;
                end
              end
              ple_pkg::CMD_FIND: begin
                idx   <= '0;
                state <= S_FIND;
              end
              ple_pkg::CMD_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        // shift up from the tail, then drop the new value in at pos
        S_INS: begin
          if (idx > pos) begin
            pend      <= 1'b1;
            pend_addr <= idx[ple_pkg::ADDR_W-1:0];
            idx       <= idx - ple_pkg::CNT_W'(1);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            count <= count + ple_pkg::CNT_W'(1);
            state <= S_RESP;
          end
        end
        // shift down toward pos, one entry per cycle
        S_DEL: begin
          if (idx < count) begin
            pend      <= 1'b1;
            pend_addr <= idx_m1[ple_pkg::ADDR_W-1:0];
            idx       <= idx + ple_pkg::CNT_W'(1);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            count <= count_m1;
            state <= S_RESP;
          end
        end
        S_RD_ISSUE: begin
          state <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          res_read <= rd_data;
          state    <= S_RESP;
        end
        S_FIND: begin
          if (pend && (rd_data == val)) begin
            pend      <= 1'b0;
            res_found <= ple_pkg::FOUND_W'(pend_addr);
            state     <= S_RESP;
          end else if (idx < count) begin
            pend      <= 1'b1;
            pend_addr <= idx[ple_pkg::ADDR_W-1:0];
            idx       <= idx + ple_pkg::CNT_W'(1);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            res_status <= ple_pkg::ST_NOTFOUND;
            state      <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            read_value     <= res_read;
            found_position <= res_found;
            entry_count    <= count;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ple_pkg::CNT_W'(ple_pkg::CAP))
    else $error("list count above capacity");

  a_port_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("RAM read and write hit the same entry");

  a_pend_scope: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_INS || state == S_DEL || state == S_FIND))
    else $error("pending write-back outside a shift or search");

  a_resp_beat: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && (!out_valid || !out_stall)) |=> (out_valid && state == S_IDLE))
    else $error("result beat not loaded");

endmodule
